FILE: src/i2cm_pkg.sv
// Shared types and constants of the I2C master register access unit.
// No dependencies; imported by i2cm_core and the top level.
package i2cm_pkg;

  // Command codes of an input transfer.
  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Configuration register indexes and reset values.
  localparam logic       REG_HALF_PERIOD   = 1'b0;
  localparam logic [7:0] HALF_PERIOD_RESET = 8'd2;

  // Most significant bit of a byte, sent first on the bus.
  localparam logic [7:0] BIT7_MASK = 8'h80;

  // One input item: a tick of the bus sequencer, possibly with a request.
  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] device_addr;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic [7:0] byte_count;
    logic       sda_in;
  } item_t;

  // One result item: pin levels and received byte for that tick.
  typedef struct packed {
    logic       scl;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       rx_last;
  } rslt_t;

endpackage

FILE: src/i2cm_core.sv
// Bus sequencer of the I2C master: holds the transaction state and works out
// the pin levels for one tick. Depends on i2cm_pkg.
module i2cm_core
  import i2cm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  item_t      item,
  input  logic [7:0] half_period,
  output rslt_t      rslt
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_S1, ST_RS1, ST_S2, ST_S3, ST_S4, ST_TXL, ST_TXH, ST_TAL,
    ST_TAH, ST_RXL, ST_RXH, ST_MAL, ST_MAH, ST_P1, ST_P2, ST_P3
  } step_t;

  step_t       step_r, step_nxt, step_acc;
  logic [3:0]  bit_r, bit_nxt, bit_acc;
  logic [7:0]  bytes_r, bytes_nxt, bytes_acc;
  logic [7:0]  shift_r, shift_nxt, shift_acc;
  logic [7:0]  hold_r, hold_nxt, hold_acc, hold_inc;
  logic [7:0]  dev_r, dev_nxt;
  logic [7:0]  regb_r, regb_nxt;
  logic [7:0]  third_r, third_nxt;
  logic [1:0]  cmd_r, cmd_nxt;
  logic [7:0]  hp;
  logic        tx_bit;
  logic        is_write;

  // Byte to send next, chosen by how many bytes have gone out already.
  function automatic logic [7:0] tx_byte(input logic [7:0] sent, input logic wr,
                                         input logic [7:0] dev,
                                         input logic [7:0] regb,
                                         input logic [7:0] data);
    logic [7:0] b;
    if (sent == 8'd0) begin
      b = dev;
    end else if (sent == 8'd1) begin
      b = regb;
    end else if (wr) begin
      b = data;
    end else begin
      b = dev | 8'd1;
    end
    return b;
  endfunction

  always_comb begin
    hp     = (half_period == 8'd0) ? 8'd1 : half_period;
    tx_bit = |(shift_r & BIT7_MASK);

    // A request is latched only when the bus is idle.
    step_acc  = step_r;
    bit_acc   = bit_r;
    bytes_acc = bytes_r;
    shift_acc = shift_r;
    hold_acc  = hold_r;
    dev_nxt   = dev_r;
    regb_nxt  = regb_r;
    third_nxt = third_r;
    cmd_nxt   = cmd_r;
    if (step_r == ST_IDLE && (item.cmd == CMD_WRITE || item.cmd == CMD_READ)) begin
      dev_nxt   = item.device_addr;
      regb_nxt  = item.reg_addr;
      third_nxt = (item.cmd == CMD_WRITE) ? item.write_data : item.byte_count;
      cmd_nxt   = item.cmd;
      step_acc  = ST_S1;
      hold_acc  = 8'd0;
      bytes_acc = 8'd0;
      bit_acc   = 4'd0;
      shift_acc = 8'd0;
    end
    is_write = (cmd_nxt == CMD_WRITE);

    rslt = '{scl: 1'b1, sda_level: 1'b1, sda_drive: 1'b0, busy_res: 1'b1,
             rx_valid: 1'b0, rx_byte: 8'd0, rx_last: 1'b0};
    unique case (step_acc)
      ST_S1, ST_S2, ST_P3: begin
        rslt.sda_drive = 1'b1;
      end
      ST_RS1: begin
        rslt.scl = 1'b0;
        rslt.sda_drive = 1'b1;
      end
      ST_S3, ST_P2: begin
        rslt.sda_level = 1'b0;
        rslt.sda_drive = 1'b1;
      end
      ST_S4, ST_P1: begin
        rslt.scl = 1'b0;
        rslt.sda_level = 1'b0;
        rslt.sda_drive = 1'b1;
      end
      ST_TXL: begin
        rslt.scl = 1'b0;
        rslt.sda_level = tx_bit;
        rslt.sda_drive = 1'b1;
      end
      ST_TXH: begin
        rslt.sda_level = tx_bit;
        rslt.sda_drive = 1'b1;
      end
      ST_TAL, ST_RXL: begin
        rslt.scl = 1'b0;
      end
      ST_TAH, ST_RXH: begin
        rslt.scl = 1'b1;
      end
      ST_MAL, ST_MAH: begin
        rslt.scl = (step_acc == ST_MAH);
        rslt.sda_level = (bytes_acc <= 8'd1);
        rslt.sda_drive = 1'b1;
      end
      default: begin
        rslt.busy_res = 1'b0;
      end
    endcase

    step_nxt  = step_acc;
    bit_nxt   = bit_acc;
    bytes_nxt = bytes_acc;
    shift_nxt = shift_acc;
    hold_nxt  = hold_acc;
    hold_inc  = hold_acc + 8'd1;

    if (rslt.busy_res) begin
      if (hold_acc == 8'd0) begin
        if (step_acc == ST_RXH) begin
          shift_nxt = {shift_acc[6:0], item.sda_in};
        end
        if (step_acc == ST_MAL) begin
          rslt.rx_valid = 1'b1;
          rslt.rx_byte  = shift_acc;
          rslt.rx_last  = (bytes_acc <= 8'd1);
        end
      end
      if (hold_inc >= hp || hold_inc == 8'd0) begin
        hold_nxt = 8'd0;
        unique case (step_acc)
          ST_S1, ST_RS1: step_nxt = ST_S2;
          ST_S2:         step_nxt = ST_S3;
          ST_S3:         step_nxt = ST_S4;
          ST_S4: begin
            shift_nxt = tx_byte(bytes_acc, is_write, dev_nxt, regb_nxt, third_nxt);
            bit_nxt   = 4'd0;
            step_nxt  = ST_TXL;
          end
          ST_TXL: step_nxt = ST_TXH;
          ST_TXH: begin
            shift_nxt = {shift_nxt[6:0], 1'b0};
            bit_nxt   = bit_acc + 4'd1;
            step_nxt  = (bit_nxt >= 4'd8) ? ST_TAL : ST_TXL;
          end
          ST_TAL: step_nxt = ST_TAH;
          ST_TAH: begin
            if (bytes_acc == 8'd0) begin
              bytes_nxt = 8'd1;
              shift_nxt = tx_byte(8'd1, is_write, dev_nxt, regb_nxt, third_nxt);
              bit_nxt   = 4'd0;
              step_nxt  = ST_TXL;
            end else if (bytes_acc == 8'd1) begin
              bytes_nxt = 8'd2;
              if (is_write) begin
                shift_nxt = tx_byte(8'd2, is_write, dev_nxt, regb_nxt, third_nxt);
                bit_nxt   = 4'd0;
                step_nxt  = ST_TXL;
              end else begin
                step_nxt = ST_RS1;
              end
            end else if (is_write) begin
              step_nxt = ST_P1;
            end else begin
              bytes_nxt = (third_nxt == 8'd0) ? 8'd1 : third_nxt;
              bit_nxt   = 4'd0;
              shift_nxt = 8'd0;
              step_nxt  = ST_RXL;
            end
          end
          ST_RXL: step_nxt = ST_RXH;
          ST_RXH: begin
            bit_nxt  = bit_acc + 4'd1;
            step_nxt = (bit_nxt >= 4'd8) ? ST_MAL : ST_RXL;
          end
          ST_MAL: step_nxt = ST_MAH;
          ST_MAH: begin
            bytes_nxt = (bytes_acc != 8'd0) ? bytes_acc - 8'd1 : 8'd0;
            if (bytes_nxt == 8'd0) begin
              step_nxt = ST_P1;
            end else begin
              bit_nxt   = 4'd0;
              shift_nxt = 8'd0;
              step_nxt  = ST_RXL;
            end
          end
          ST_P1:   step_nxt = ST_P2;
          ST_P2:   step_nxt = ST_P3;
          default: step_nxt = ST_IDLE;
        endcase
      end else begin
        hold_nxt = hold_inc;
      end
    end else begin
      step_nxt = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= ST_IDLE;
      bit_r   <= 4'd0;
      bytes_r <= 8'd0;
      shift_r <= 8'd0;
      hold_r  <= 8'd0;
      dev_r   <= 8'd0;
      regb_r  <= 8'd0;
      third_r <= 8'd0;
      cmd_r   <= CMD_NONE;
    end else if (en) begin
      step_r  <= step_nxt;
      bit_r   <= bit_nxt;
      bytes_r <= bytes_nxt;
      shift_r <= shift_nxt;
      hold_r  <= hold_nxt;
      dev_r   <= dev_nxt;
      regb_r  <= regb_nxt;
      third_r <= third_nxt;
      cmd_r   <= cmd_nxt;
    end
  end

  // Without an enable the sequencer keeps its step.
  assert property (@(posedge clk) disable iff (!rst_n)
    (!en) |=> $stable(step_r))
    else $error("sequencer moved without an enable");

  // While idle the hold counter stays cleared.
  assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == ST_IDLE) |-> (hold_r == 8'd0))
    else $error("hold counter not cleared while idle");

  // Bit counter stays within a byte, at most 8, in every step.
  assert property (@(posedge clk) disable iff (!rst_n)
    (bit_r <= 4'd8))
    else $error("bit counter out of range");

endmodule

FILE: src/i2c_master_register_access_unit.sv
// Top level of the I2C master register access unit: handshakes, input and
// result registers, and the configuration port. Uses i2cm_pkg and i2cm_core.
//
// A result passes from the input register through the result register; a held
// output can keep it waiting in either register before it is presented.
// Throughput: one item per clock while the output is not held; each is one
// tick of the bus sequencer, worked out in a single pass through i2cm_core.
// Reset (synchronous, rst_n low): the bus is idle, all counters cleared and
// half_period returns to 2. No clearing pass is needed.
module i2c_master_register_access_unit
  import i2cm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input channel: one tick of the sequencer per transfer.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_device_addr,
  input  logic [7:0]  in_reg_addr,
  input  logic [7:0]  in_write_data,
  input  logic [7:0]  in_byte_count,
  input  logic        in_sda_in,
  // Result channel: pin levels and received data for that tick.
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_scl,
  output logic        out_sda_level,
  output logic        out_sda_drive,
  output logic        out_busy_res,
  output logic        out_rx_valid,
  output logic [7:0]  out_rx_byte,
  output logic        out_rx_last,
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic       in_valid_r;
  item_t      item_r;
  logic       res_valid_r;
  rslt_t      rslt_r;
  rslt_t      core_rslt;
  logic [7:0] half_period_r;
  logic       res_free;
  logic       core_en;
  logic       cfg_wr;

  // The result register can take a new result when it is empty or being
  // drained this cycle. The input register moves on under the same rule, so
  // a transfer is stalled only while both stages are full and the output
  // is held.
  assign res_free = !res_valid_r || !out_stall;
  assign core_en  = in_valid_r && res_free;
  assign in_stall = in_valid_r && !res_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  // Payload of the input register needs no reset.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= '{cmd: in_cmd, device_addr: in_device_addr, reg_addr: in_reg_addr,
                  write_data: in_write_data, byte_count: in_byte_count,
                  sda_in: in_sda_in};
    end
  end

  // The sequencer state advances exactly once for each item that passes on
  // to the result register.
  i2cm_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (core_en),
    .item        (item_r),
    .half_period (half_period_r),
    .rslt        (core_rslt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (res_free) begin
      res_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (core_en) begin
      rslt_r <= core_rslt;
    end
  end

  assign out_valid     = res_valid_r;
  assign out_scl       = rslt_r.scl;
  assign out_sda_level = rslt_r.sda_level;
  assign out_sda_drive = rslt_r.sda_drive;
  assign out_busy_res  = rslt_r.busy_res;
  assign out_rx_valid  = rslt_r.rx_valid;
  assign out_rx_byte   = rslt_r.rx_byte;
  assign out_rx_last   = rslt_r.rx_last;

  // Configuration: a single register at byte address 0. Writes to any other
  // word are dropped and read back as zero.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= HALF_PERIOD_RESET;
    end else if (cfg_wr && cfg_paddr[2] == REG_HALF_PERIOD) begin
      half_period_r <= cfg_pwdata[7:0];
    end
  end

  always_comb begin
    cfg_prdata = 32'd0;
    if (cfg_paddr[2] == REG_HALF_PERIOD) begin
      cfg_prdata = {24'd0, half_period_r};
    end
  end

  // A stall on the input side only arises from a held, full result register.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without back-pressure from the output");

  // A received byte is only ever presented during a transaction.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rx_valid) |-> out_busy_res)
    else $error("received byte outside a transaction");

  // The received byte fields stay cleared when no byte is presented.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_rx_valid) |-> (out_rx_byte == 8'd0 && !out_rx_last))
    else $error("received byte fields set without a received byte");

  // A write to the half period register takes effect at the next edge.
  assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && cfg_paddr[2] == REG_HALF_PERIOD) |=>
      (half_period_r == $past(cfg_pwdata[7:0])))
    else $error("half period write lost");

endmodule
